/* design/assert_macros.svh */
// Assertion helpers for the design files; the top-level file includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);
`define ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, cond, expr, msg)
`define ASSERT_NEXT(label, clk, rst, cond, expr, msg)
`endif
`endif

/* design/l4hc_pkg.sv */
`timescale 1ns / 1ps
package l4hc_pkg;

  localparam logic [1:0] VERDICT_MATCH    = 2'd0;
  localparam logic [1:0] VERDICT_NO_MATCH = 2'd1;
  localparam logic [1:0] VERDICT_INVALID  = 2'd2;

  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [3:0] IP_VERSION = 4'd4;

  // Byte positions relative to the start of the IP header.
  localparam logic [15:0] IP_PROTO_POS = 16'd9;
  localparam logic [15:0] IP_SRC_POS   = 16'd12;
  localparam logic [15:0] IP_DST_POS   = 16'd16;
  localparam logic [15:0] IP_MIN_HDR   = 16'd20;

  // Byte position of the data offset within the TCP header.
  localparam logic [15:0] TCP_DOFF_POS = 16'd12;
  localparam logic [15:0] UDP_HDR      = 16'd8;
  localparam logic [15:0] TCP_MIN_HDR  = 16'd20;

  localparam logic [15:0] MATCH_PORT_RESET = 16'd53;

  typedef struct packed {
    logic [15:0] byte_count;
    logic        overflow;
    logic [7:0]  ver_ihl;
    logic [7:0]  proto;
    logic [31:0] ip_source;
    logic [31:0] ip_dest;
    logic [15:0] l4_source;
    logic [15:0] l4_dest;
    logic [3:0]  tcp_doff;
  } frame_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [7:0]  proto;
    logic [31:0] ip_source;
    logic [31:0] ip_dest;
    logic [15:0] l4_source;
    logic [15:0] l4_dest;
    logic [15:0] poff;
    logic [15:0] plen;
  } result_t;

endpackage

/* design/l4hc_capture.sv */
`timescale 1ns / 1ps
module l4hc_capture
  import l4hc_pkg::*;
#(
  parameter int LINK_HEADER_BYTES = 14,
  parameter int MAX_FRAME_BYTES   = 65535
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output frame_t     frame_next
);

  localparam logic [15:0] LINK16 = 16'(LINK_HEADER_BYTES);
  localparam logic [15:0] MAX16  = 16'(MAX_FRAME_BYTES);

  frame_t      frame;
  logic [15:0] pos;
  logic [15:0] ip_hl;
  logic [15:0] l4_start;

  assign pos      = frame.byte_count;
  assign ip_hl    = {10'd0, frame.ver_ihl[3:0], 2'b00};
  assign l4_start = LINK16 + ip_hl;

  always_comb begin
    frame_next = frame;
    if (pos < MAX16) begin
      if (pos == LINK16) begin
        frame_next.ver_ihl = data_byte;
      end else if (pos == LINK16 + IP_PROTO_POS) begin
        frame_next.proto = data_byte;
      end else if (pos >= LINK16 + IP_SRC_POS && pos < LINK16 + IP_DST_POS) begin
        frame_next.ip_source = {frame.ip_source[23:0], data_byte};
      end else if (pos >= LINK16 + IP_DST_POS && pos < LINK16 + IP_MIN_HDR) begin
        frame_next.ip_dest = {frame.ip_dest[23:0], data_byte};
      end
      // The transport header is located only once a sane header length is known.
      if (ip_hl >= IP_MIN_HDR) begin
        if (pos == l4_start || pos == l4_start + 16'd1) begin
          frame_next.l4_source = {frame.l4_source[7:0], data_byte};
        end else if (pos == l4_start + 16'd2 || pos == l4_start + 16'd3) begin
          frame_next.l4_dest = {frame.l4_dest[7:0], data_byte};
        end else if (pos == l4_start + TCP_DOFF_POS) begin
          frame_next.tcp_doff = data_byte[7:4];
        end
      end
      frame_next.byte_count = pos + 16'd1;
    end else begin
      frame_next.overflow = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame <= '0;
    end else if (step) begin
      frame <= last_byte ? '0 : frame_next;
    end
  end

endmodule

/* design/l4hc_judge.sv */
`timescale 1ns / 1ps
module l4hc_judge
  import l4hc_pkg::*;
#(
  parameter int LINK_HEADER_BYTES = 14
) (
  input  frame_t      frame,
  input  logic [15:0] match_port,
  output result_t     res
);

  localparam logic [15:0] LINK16 = 16'(LINK_HEADER_BYTES);

  logic [15:0] n;
  logic [15:0] ip_hl;
  logic [15:0] l4_hl;
  logic [15:0] l4_min;
  logic [15:0] hdr_end;
  logic [15:0] poff;
  logic        is_udp;
  logic        is_tcp;
  logic        ok;
  logic        hit;

  assign n       = frame.byte_count;
  assign is_udp  = frame.proto == PROTO_UDP;
  assign is_tcp  = frame.proto == PROTO_TCP;
  assign ip_hl   = {10'd0, frame.ver_ihl[3:0], 2'b00};
  assign l4_hl   = is_udp ? UDP_HDR : {10'd0, frame.tcp_doff, 2'b00};
  assign l4_min  = is_udp ? UDP_HDR : TCP_MIN_HDR;
  assign hdr_end = LINK16 + ip_hl;
  assign poff    = hdr_end + l4_hl;

  // Every length check is a compare of the byte count against a short sum, so
  // all of them run side by side.
  assign ok = !frame.overflow
           && n >= LINK16 + IP_MIN_HDR
           && frame.ver_ihl[7:4] == IP_VERSION
           && ip_hl >= IP_MIN_HDR
           && (is_udp || is_tcp)
           && n >= hdr_end + l4_min
           && l4_hl >= l4_min
           && n >= poff;

  assign hit = frame.l4_source == match_port || frame.l4_dest == match_port;

  always_comb begin
    res = '0;
    if (ok) begin
      res.verdict   = hit ? VERDICT_MATCH : VERDICT_NO_MATCH;
      res.proto     = frame.proto;
      res.ip_source = frame.ip_source;
      res.ip_dest   = frame.ip_dest;
      res.l4_source = frame.l4_source;
      res.l4_dest   = frame.l4_dest;
      res.poff      = poff;
      res.plen      = n - poff;
    end else begin
      res.verdict = VERDICT_INVALID;
    end
  end

endmodule

/* design/ipv4_l4_header_classifier_top.sv */
`timescale 1ns / 1ps
// Path: a frame's final byte moves from the input byte register to the frame snapshot, then to the result register.
// Throughput: one byte per cycle while in_stall is low; a final byte stalls until the frame snapshot
// has room. The per-byte field capture and the length checks each fit between two registers.
// Reset (synchronous, active high) empties the pipeline, clears the frame state
// and sets the match port to 53.
`include "assert_macros.svh"
module ipv4_l4_header_classifier_top
  import l4hc_pkg::*;
#(
  parameter int LINK_HEADER_BYTES = 14,
  parameter int MAX_FRAME_BYTES   = 65535
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  verdict,
  output logic [7:0]  proto_number,
  output logic [31:0] source_address,
  output logic [31:0] dest_address,
  output logic [15:0] source_port,
  output logic [15:0] dest_port,
  output logic [15:0] payload_offset,
  output logic [15:0] payload_length
);

  logic [15:0] match_port;

  logic        s0_valid;
  logic [7:0]  s0_byte;
  logic        s0_last;
  logic        s0_adv;

  logic        snap_valid;
  frame_t      snap;
  frame_t      frame_next;
  logic        snap_move;
  logic        snap_free;

  result_t     judged;
  result_t     out_res;
  logic        out_free;

  logic        out_invalid;
  logic        out_ok;
  logic        fields_zero;
  logic        proto_ok;

  assign out_free  = !out_valid || !out_stall;
  assign snap_move = snap_valid && out_free;
  assign snap_free = !snap_valid || snap_move;
  // Only a final byte needs room downstream; other bytes just update the state.
  assign s0_adv    = s0_valid && (!s0_last || snap_free);
  assign in_stall  = s0_valid && !s0_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_port <= MATCH_PORT_RESET;
    end else if (cfg_write_en) begin
      match_port <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (!in_stall) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s0_byte <= data_byte;
      s0_last <= last_byte;
    end
  end

  l4hc_capture #(
    .LINK_HEADER_BYTES(LINK_HEADER_BYTES),
    .MAX_FRAME_BYTES  (MAX_FRAME_BYTES)
  ) u_capture (
    .clk       (clk),
    .rst       (rst),
    .step      (s0_adv),
    .data_byte (s0_byte),
    .last_byte (s0_last),
    .frame_next(frame_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (snap_free) begin
      snap_valid <= s0_adv && s0_last;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_free && s0_adv && s0_last) begin
      snap <= frame_next;
    end
  end

  l4hc_judge #(
    .LINK_HEADER_BYTES(LINK_HEADER_BYTES)
  ) u_judge (
    .frame     (snap),
    .match_port(match_port),
    .res       (judged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_move) begin
      out_res <= judged;
    end
  end

  assign verdict        = out_res.verdict;
  assign proto_number   = out_res.proto;
  assign source_address = out_res.ip_source;
  assign dest_address   = out_res.ip_dest;
  assign source_port    = out_res.l4_source;
  assign dest_port      = out_res.l4_dest;
  assign payload_offset = out_res.poff;
  assign payload_length = out_res.plen;

  assign out_invalid = out_valid && verdict == VERDICT_INVALID;
  assign out_ok      = out_valid && verdict != VERDICT_INVALID;
  assign fields_zero = proto_number == 8'd0 && source_port == 16'd0 && dest_port == 16'd0
                    && payload_offset == 16'd0 && payload_length == 16'd0;
  assign proto_ok    = proto_number == PROTO_UDP || proto_number == PROTO_TCP;

  `ASSERT_IMPLIES(a_stall_on_last, clk, rst, in_stall, s0_valid && s0_last, "stall on non-final item")
  `ASSERT_IMPLIES(a_invalid_zero, clk, rst, out_invalid, fields_zero, "invalid verdict with nonzero fields")
  `ASSERT_IMPLIES(a_valid_proto, clk, rst, out_ok, proto_ok, "valid verdict on other protocol")
  `ASSERT_NEXT(a_snap_taken, clk, rst, snap_move, out_valid, "judged frame not presented")

endmodule
